>>> rtl/core/hsdp_pkg.sv
// Shared types, constants and syntax tables for the SPS dimension parser.
package hsdp_pkg;

  localparam int DIM_BITS_DEF = 16;
  localparam int QUEUE_DEPTH  = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] width;
    logic [15:0] height;
  } out_item_t;

  // front-to-back command: a byte to parse bit by bit or to skip, with the end marker and a no-SPS flag
  typedef struct packed {
    logic       parse;
    logic [7:0] bits;
    logic       last;
    logic       no_sps;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_SPS  = 3'd1,
    ST_TRUNC   = 3'd2,
    ST_CHROMA  = 3'd3,
    ST_CPB     = 3'd4,
    ST_BAD_DIM = 3'd5
  } status_t;

  localparam logic [6:0] PT_PROFILE = 7'd0;
  localparam logic [6:0] PT_SPSID = 7'd3;
  localparam logic [6:0] PT_CHROMA = 7'd4;
  localparam logic [6:0] PT_SEPCOL = 7'd5;
  localparam logic [6:0] PT_DEPTHL = 7'd6;
  localparam logic [6:0] PT_SMFLAG = 7'd9;
  localparam logic [6:0] PT_SLFLAG = 7'd10;
  localparam logic [6:0] PT_DELTA = 7'd11;
  localparam logic [6:0] PT_LOG2FN = 7'd12;
  localparam logic [6:0] PT_POCTYPE = 7'd13;
  localparam logic [6:0] PT_POCLSB = 7'd14;
  localparam logic [6:0] PT_DZERO = 7'd15;
  localparam logic [6:0] PT_NCYCLE = 7'd18;
  localparam logic [6:0] PT_OFFREF = 7'd19;
  localparam logic [6:0] PT_NUMREF = 7'd20;
  localparam logic [6:0] PT_WIDTH = 7'd22;
  localparam logic [6:0] PT_HEIGHT = 7'd23;
  localparam logic [6:0] PT_FMO = 7'd24;
  localparam logic [6:0] PT_MBAFF = 7'd25;
  localparam logic [6:0] PT_D8 = 7'd26;
  localparam logic [6:0] PT_CROPF = 7'd27;
  localparam logic [6:0] PT_CROP = 7'd28;
  localparam logic [6:0] PT_VUIF = 7'd29;
  localparam logic [6:0] PT_ARF = 7'd30;
  localparam logic [6:0] PT_ARIDC = 7'd31;
  localparam logic [6:0] PT_SAR = 7'd32;
  localparam logic [6:0] PT_OVF = 7'd33;
  localparam logic [6:0] PT_OVA = 7'd34;
  localparam logic [6:0] PT_VSF = 7'd35;
  localparam logic [6:0] PT_VFMT = 7'd36;
  localparam logic [6:0] PT_CDF = 7'd37;
  localparam logic [6:0] PT_COLOUR = 7'd38;
  localparam logic [6:0] PT_CLF = 7'd39;
  localparam logic [6:0] PT_CLOC = 7'd40;
  localparam logic [6:0] PT_TIF = 7'd41;
  localparam logic [6:0] PT_TICK = 7'd42;
  localparam logic [6:0] PT_NALHRD = 7'd44;
  localparam logic [6:0] PT_VCLHRD = 7'd45;
  localparam logic [6:0] PT_CPBCNT = 7'd46;
  localparam logic [6:0] PT_SCALES = 7'd47;
  localparam logic [6:0] PT_BITRATE = 7'd48;
  localparam logic [6:0] PT_CBR = 7'd50;
  localparam logic [6:0] PT_DELAYS = 7'd51;
  localparam logic [6:0] PT_LOWDELAY = 7'd52;
  localparam logic [6:0] PT_PICSTRUCT = 7'd53;
  localparam logic [6:0] PT_BRF = 7'd54;
  localparam logic [6:0] PT_MVOB = 7'd55;
  localparam logic [6:0] PT_RESTR = 7'd56;
  localparam logic [6:0] PT_DONE = 7'd57;

  // fixed field length per syntax point, zero for Exp-Golomb
  function automatic logic [5:0] elem_len(input logic [6:0] p);
    case (p)
      7'd0, 7'd1, 7'd2, 7'd31, 7'd47: elem_len = 6'd8;
      7'd5, 7'd8, 7'd9, 7'd10, 7'd15, 7'd21, 7'd24, 7'd25, 7'd26, 7'd27,
      7'd29, 7'd30, 7'd33, 7'd34, 7'd35, 7'd37, 7'd39, 7'd41, 7'd44, 7'd45,
      7'd50, 7'd52, 7'd53, 7'd54, 7'd55: elem_len = 6'd1;
      7'd32, 7'd42: elem_len = 6'd32;
      7'd43: elem_len = 6'd33;
      7'd36: elem_len = 6'd4;
      7'd38: elem_len = 6'd24;
      7'd40: elem_len = 6'd10;
      7'd51: elem_len = 6'd20;
      default: elem_len = 6'd0;
    endcase
  endfunction

  function automatic logic high_profile(input logic [7:0] p);
    high_profile = p inside {8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86,
                             8'd118, 8'd128, 8'd138, 8'd139, 8'd134, 8'd135};
  endfunction

  function automatic logic [1:0] crop_w_unit(input logic [1:0] c);
    crop_w_unit = (c == 2'd1 || c == 2'd2) ? 2'd2 : 2'd1;
  endfunction

  function automatic logic [1:0] crop_h_unit(input logic [1:0] c);
    crop_h_unit = (c == 2'd1) ? 2'd2 : 2'd1;
  endfunction

endpackage

>>> rtl/core/h264_sps_dimension_parser.sv
// Top level of the SPS dimension parser.
// Usage:
//   Input channel is a queue: present in_item and raise push while full is low;
//   every such edge transfers one stream byte with its last-byte flag.
//   Result channel is a queue: while empty is low, out_item holds the result of
//   the buffer just closed; raise pop to transfer it. One result per buffer,
//   given on the byte flagged last, none otherwise.
// Timing:
//   The front end classifies each byte combinationally and hands it through a
//   four-entry command queue. The back end walks SPS payload bytes one bit per
//   cycle: it takes the command, then steps through the bits; a byte outside
//   the SPS is only taken. After the last byte, the size arithmetic runs
//   through S_FIN1, S_FIN2 and S_FIN3 before out_item appears.
//   The back end takes no further command while its result waits, so a stalled
//   receiver fills the queue and then raises full.
// Reset: rst_n synchronous active low, clears control state; no result waits.
module h264_sps_dimension_parser import hsdp_pkg::*; #(
  parameter int DIM_BITS = DIM_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  logic      push,
  output logic      full,
  output out_item_t out_item,
  output logic      empty,
  input  logic      pop
);

  cmd_t fcmd, qcmd;
  logic qempty, qtake, rvalid;

  hsdp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .take(push && !full), .cmd(fcmd)
  );

  hsdp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(push), .wr_data(fcmd), .full(full),
    .rd_en(qtake), .rd_data(qcmd), .empty(qempty)
  );

  hsdp_back #(.DIM_BITS(DIM_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd(qcmd), .cmd_valid(!qempty), .cmd_take(qtake),
    .res(out_item), .res_valid(rvalid), .res_take(pop)
  );

  assign empty = !rvalid;

endmodule

>>> rtl/core/hsdp_front.sv
// Byte front end: start code search, NAL header check, emulation byte drop.
module hsdp_front import hsdp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  in_item_t in_item,
  input  logic     take,
  output cmd_t     cmd
);

  logic [1:0] zero_run_r, zero_run_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [1:0] zinc;

  assign zinc = (in_item.data_byte == 8'd0) ? ((zero_run_r < 2'd2) ? zero_run_r + 2'd1 : 2'd2)
                                            : 2'd0;

  always_comb begin
    zero_run_nxt = zero_run_r;
    phase_nxt    = phase_r;
    cmd.parse    = 1'b0;
    cmd.bits     = in_item.data_byte;
    cmd.last     = in_item.last_byte;
    cmd.no_sps   = 1'b0;
    case (phase_r)
      2'd0: begin
        if (in_item.data_byte == 8'd1 && zero_run_r == 2'd2) begin
          phase_nxt = 2'd1;
          zero_run_nxt = 2'd0;
        end else begin
          zero_run_nxt = zinc;
        end
        cmd.no_sps = 1'b1;
      end
      2'd1: begin
        if ((in_item.data_byte & 8'h1F) == 8'h07) begin
          phase_nxt = 2'd2;
          zero_run_nxt = 2'd0;
        end else begin
          phase_nxt = 2'd0;
          zero_run_nxt = (in_item.data_byte == 8'd0) ? 2'd1 : 2'd0;
          cmd.no_sps = 1'b1;
        end
      end
      default: begin
        if (zero_run_r == 2'd2 && in_item.data_byte == 8'd3) begin
          zero_run_nxt = 2'd0;
        end else begin
          cmd.parse = 1'b1;
          zero_run_nxt = zinc;
        end
      end
    endcase
    if (in_item.last_byte) begin
      zero_run_nxt = 2'd0;
      phase_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r <= 2'd0;
      phase_r <= 2'd0;
    end else if (take) begin
      zero_run_r <= zero_run_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

>>> rtl/core/hsdp_queue.sv
// Short command queue between the byte front end and the bit parser.
module hsdp_queue import hsdp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t           mem_r [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en && !full) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd_en && !empty) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
    end
  end

endmodule

>>> rtl/core/hsdp_back.sv
// Bit-serial SPS syntax walker and final size computation.
module hsdp_back import hsdp_pkg::*; #(
  parameter int DIM_BITS = DIM_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  logic      cmd_valid,
  output logic      cmd_take,
  output out_item_t res,
  output logic      res_valid,
  input  logic      res_take
);

  typedef enum logic [2:0] {S_IDLE, S_BITS, S_FIN1, S_FIN2, S_FIN3, S_OUT} state_t;

  state_t      state_r;
  logic [2:0]  bit_r;
  logic [7:0]  byte_r;
  logic        last_r, nosps_r;
  logic        parsing_r;
  logic [6:0]  pt_r;
  logic [5:0]  gz_r;
  logic [31:0] acc_r;
  logic [7:0]  loop_r;
  logic [7:0]  nscale_r;
  logic [7:0]  prof_r;
  logic [1:0]  chroma_r;
  logic [31:0] size_r [2];
  logic [31:0] crop_r [4];
  logic [3:0]  flag_r;
  logic [2:0]  err_r;
  // size computation pipeline
  logic [33:0] cwsum_r, chsum_r;
  logic [36:0] w_r;
  logic [37:0] h_r;
  logic [36:0] cw_r;
  logic [37:0] ch_r;

  // single-bit step
  logic        b;
  logic [5:0]  len;
  logic        fin;
  logic [31:0] fv;
  logic [31:0] acc_sh;
  logic [4:0]  rem;

  assign b      = byte_r[bit_r];
  assign len    = elem_len(pt_r);
  assign acc_sh = {acc_r[30:0], b};
  assign rem    = gz_r[4:0] - 5'd1;

  logic [5:0]  gz_nxt;
  logic [31:0] acc_nxt;
  logic        fail2;
  logic        active;

  assign active = parsing_r && (pt_r < PT_DONE);

  always_comb begin
    gz_nxt = gz_r;
    acc_nxt = acc_r;
    fin = 1'b0;
    fv = acc_sh;
    fail2 = 1'b0;
    if (len != 6'd0) begin
      acc_nxt = acc_sh;
      gz_nxt = gz_r + 6'd1;
      if (gz_nxt >= len) fin = 1'b1;
    end else if (gz_r[5]) begin
      acc_nxt = acc_sh;
      gz_nxt = {1'b1, rem};
      if (rem == 5'd0) begin
        fin = 1'b1;
        fv = acc_sh - 32'd1;
      end
    end else if (b) begin
      if (gz_r == 6'd0) begin
        fin = 1'b1;
        fv = 32'd0;
      end else begin
        acc_nxt = 32'd1;
        gz_nxt = gz_r | 6'd32;
      end
    end else if (gz_r >= 6'd31) begin
      fail2 = 1'b1;
    end else begin
      gz_nxt = gz_r + 6'd1;
    end
    // clear the field for the next syntax element
    if (fin) begin
      gz_nxt = '0;
      acc_nxt = '0;
    end
  end

  // scaling delta
  logic [31:0] dlt;
  logic [7:0]  snew;
  logic [7:0]  loop_inc;
  assign dlt      = fv[0] ? (fv >> 1) + 32'd1 : 32'd0 - (fv >> 1);
  assign snew     = nscale_r + dlt[7:0];
  assign loop_inc = loop_r + 8'd1;

  logic [31:0] s1_inc;
  logic        list_more;
  assign s1_inc    = size_r[1] + 32'd1;
  assign list_more = s1_inc < ((chroma_r == 2'd3) ? 32'd12 : 32'd8);

  logic [31:0] lim;
  assign lim = 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_valid <= 1'b0;
      parsing_r <= 1'b0;
      pt_r <= PT_PROFILE;
      gz_r <= '0;
      acc_r <= '0;
      loop_r <= '0;
      nscale_r <= 8'd8;
      prof_r <= '0;
      chroma_r <= 2'd1;
      size_r[0] <= '0;
      size_r[1] <= '0;
      for (int i = 0; i < 4; i++) crop_r[i] <= '0;
      flag_r <= '0;
      err_r <= '0;
      bit_r <= 3'd7;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            byte_r <= cmd.bits;
            last_r <= cmd.last;
            nosps_r <= cmd.no_sps;
            bit_r <= 3'd7;
            if (!cmd.no_sps) parsing_r <= 1'b1;
            if (cmd.parse) state_r <= S_BITS;
            else if (cmd.last) state_r <= S_FIN1;
          end
        end
        S_BITS: begin
          if (active) begin
            gz_r <= gz_nxt;
            acc_r <= acc_nxt;
            if (fail2) begin
              err_r <= ST_TRUNC;
              parsing_r <= 1'b0;
            end else if (fin) begin
              logic [6:0] nx;
              logic       stop;
              nx = pt_r + 7'd1;
              stop = 1'b0;
              case (pt_r)
                PT_PROFILE: prof_r <= fv[7:0];
                PT_SPSID: nx = high_profile(prof_r) ? PT_CHROMA : PT_LOG2FN;
                PT_CHROMA: begin
                  if (fv > 32'd3) begin
                    err_r <= ST_CHROMA; stop = 1'b1;
                  end else begin
                    chroma_r <= fv[1:0];
                    nx = (fv == 32'd3) ? PT_SEPCOL : PT_DEPTHL;
                  end
                end
                PT_SMFLAG: begin
                  if (fv != 0) begin size_r[1] <= '0; nx = PT_SLFLAG; end
                  else nx = PT_LOG2FN;
                end
                PT_SLFLAG: begin
                  if (fv != 0) begin
                    loop_r <= '0; nscale_r <= 8'd8; nx = PT_DELTA;
                  end else begin
                    size_r[1] <= s1_inc; nx = list_more ? PT_SLFLAG : PT_LOG2FN;
                  end
                end
                PT_DELTA: begin
                  loop_r <= loop_inc;
                  if (snew == 8'd0 ||
                      loop_inc >= ((size_r[1] < 32'd6) ? 8'd16 : 8'd64)) begin
                    size_r[1] <= s1_inc; nx = list_more ? PT_SLFLAG : PT_LOG2FN;
                  end else begin
                    nscale_r <= snew; nx = PT_DELTA;
                  end
                end
                PT_POCTYPE: nx = (fv == 0) ? PT_POCLSB : ((fv == 1) ? PT_DZERO : PT_NUMREF);
                PT_POCLSB: nx = PT_NUMREF;
                PT_NCYCLE: begin size_r[0] <= fv; nx = (fv != 0) ? PT_OFFREF : PT_NUMREF; end
                PT_OFFREF: begin
                  size_r[0] <= size_r[0] - 32'd1;
                  nx = (size_r[0] != 32'd1) ? PT_OFFREF : PT_NUMREF;
                end
                PT_WIDTH: size_r[0] <= fv;
                PT_HEIGHT: size_r[1] <= fv;
                PT_FMO: begin flag_r[0] <= fv[0]; nx = (fv != 0) ? PT_D8 : PT_MBAFF; end
                PT_CROPF: begin
                  flag_r[1] <= fv[0];
                  if (fv != 0) begin loop_r <= '0; nx = PT_CROP; end else nx = PT_VUIF;
                end
                PT_CROP: begin
                  crop_r[loop_r[1:0]] <= fv;
                  loop_r <= loop_inc;
                  nx = (loop_inc < 8'd4) ? PT_CROP : PT_VUIF;
                end
                PT_VUIF: nx = (fv != 0) ? PT_ARF : PT_DONE;
                PT_ARF: nx = (fv != 0) ? PT_ARIDC : PT_OVF;
                PT_ARIDC: nx = (fv == 32'd255) ? PT_SAR : PT_OVF;
                PT_SAR: nx = PT_OVF;
                PT_OVF: nx = (fv != 0) ? PT_OVA : PT_VSF;
                PT_VSF: nx = (fv != 0) ? PT_VFMT : PT_CLF;
                PT_CDF: nx = (fv != 0) ? PT_COLOUR : PT_CLF;
                PT_CLF: nx = (fv != 0) ? PT_CLOC : PT_TIF;
                PT_TIF: nx = (fv != 0) ? PT_TICK : PT_NALHRD;
                PT_NALHRD: begin
                  if (fv != 0) begin flag_r[3:2] <= 2'b11; nx = PT_CPBCNT; end
                  else nx = PT_VCLHRD;
                end
                PT_VCLHRD: begin
                  if (fv != 0) begin
                    flag_r[3:2] <= 2'b01; nx = PT_CPBCNT;
                  end else nx = flag_r[2] ? PT_LOWDELAY : PT_PICSTRUCT;
                end
                PT_CPBCNT: begin
                  if (fv > 32'd31) begin
                    err_r <= ST_CPB; stop = 1'b1;
                  end else begin
                    loop_r <= fv[7:0]; nx = PT_SCALES;
                  end
                end
                PT_CBR: begin
                  if (loop_r == 8'd0) nx = PT_DELAYS;
                  else begin loop_r <= loop_r - 8'd1; nx = PT_BITRATE; end
                end
                PT_DELAYS: begin
                  if (flag_r[3]) begin flag_r[3] <= 1'b0; nx = PT_VCLHRD; end
                  else nx = PT_LOWDELAY;
                end
                PT_BRF: nx = (fv != 0) ? PT_MVOB : PT_DONE;
                PT_MVOB: begin loop_r <= '0; nx = PT_RESTR; end
                PT_RESTR: begin
                  loop_r <= loop_inc; nx = (loop_inc < 8'd6) ? PT_RESTR : PT_DONE;
                end
                default: ;
              endcase
              if (stop) parsing_r <= 1'b0;
              else if (nx >= PT_DONE) pt_r <= PT_DONE;
              else pt_r <= nx;
            end
          end
          bit_r <= bit_r - 3'd1;
          if (bit_r == 3'd0) state_r <= last_r ? S_FIN1 : S_IDLE;
        end
        S_FIN1: begin
          cwsum_r <= {2'b0, crop_r[0]} + {2'b0, crop_r[1]};
          chsum_r <= {2'b0, crop_r[2]} + {2'b0, crop_r[3]};
          w_r <= {1'b0, size_r[0] + 32'd0, 4'b0} + 37'd16;
          h_r <= (({6'b0, size_r[1]} + 38'd1) << 4) << !flag_r[0];
          state_r <= S_FIN2;
        end
        S_FIN2: begin
          cw_r <= 37'(cwsum_r) * crop_w_unit(chroma_r);
          ch_r <= (38'(chsum_r) * crop_h_unit(chroma_r)) << !flag_r[0];
          state_r <= S_FIN3;
        end
        S_FIN3: begin
          logic [2:0]  st;
          logic [37:0] wf, hf;
          st = ST_OK;
          wf = {1'b0, w_r};
          hf = h_r;
          if (nosps_r && !parsing_r && pt_r == PT_PROFILE && err_r == 3'd0) st = ST_NO_SPS;
          else if (err_r != 3'd0) st = err_r;
          else if (pt_r != PT_DONE) st = ST_TRUNC;
          else begin
            if (flag_r[1]) begin
              if ({1'b0, cw_r} >= wf || ch_r >= hf) st = ST_BAD_DIM;
              else begin wf = wf - {1'b0, cw_r}; hf = hf - ch_r; end
            end
            if (st == ST_OK && ((wf >> DIM_BITS) != 0 || (hf >> DIM_BITS) != 0))
              st = ST_BAD_DIM;
          end
          res.status <= st;
          res.width  <= (st == ST_OK) ? wf[15:0] : 16'd0;
          res.height <= (st == ST_OK) ? hf[15:0] : 16'd0;
          res_valid <= 1'b1;
          state_r <= S_OUT;
          // back to reset state for the next buffer
          parsing_r <= 1'b0;
          pt_r <= PT_PROFILE;
          gz_r <= '0;
          acc_r <= lim;
          loop_r <= '0;
          nscale_r <= 8'd8;
          prof_r <= '0;
          chroma_r <= 2'd1;
          size_r[0] <= '0;
          size_r[1] <= '0;
          for (int i = 0; i < 4; i++) crop_r[i] <= '0;
          flag_r <= '0;
          err_r <= '0;
        end
        S_OUT: begin
          if (res_take) begin
            res_valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cmd_take = (state_r == S_IDLE) && cmd_valid;

endmodule

>>> rtl/core/hsdp_checker.sv
// Port-level checker for the SPS dimension parser, bound to the top level.
module hsdp_checker import hsdp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_item.status <= 3'd5))
    else $error("bad status code");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.status != ST_OK) |-> (out_item.width == 16'd0 && out_item.height == 16'd0))
    else $error("size on error result");

  a_reset: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("result or full after reset");

endmodule

bind h264_sps_dimension_parser hsdp_checker u_checker (
  .clk(clk), .rst_n(rst_n), .full(full), .empty(empty), .pop(pop),
  .out_item(out_item)
);

>>> sim/tb.sv
// Self-checking testbench for the SPS dimension parser: directed table, then random streams.
module tb;
  import hsdp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 362;
  localparam int PH_SEARCH = 0;
  localparam int PH_HEADER = 1;
  localparam int PH_WALK   = 2;
  localparam int PH_DONE   = 3;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    logic [2:0]  status;
    logic [15:0] width;
    logic [15:0] height;
  } dir_row_t;

  // typed rows: a lone byte, a bare start code, a bare SPS header, a 320x240 baseline SPS,
  // a non-SPS NAL
  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{8'hFF, 1'b1, 1'b1, ST_NO_SPS, 16'd0, 16'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'h01, 1'b1, 1'b1, ST_NO_SPS, 16'd0, 16'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'h01, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'h67, 1'b1, 1'b1, ST_TRUNC, 16'd0, 16'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'h01, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'h67, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'h42, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'h1E, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'hDA, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'h05, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'h07, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'hE4, 1'b1, 1'b1, ST_OK, 16'd320, 16'd240},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'h01, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'h08, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
    '{8'h00, 1'b1, 1'b1, ST_NO_SPS, 16'd0, 16'd0}
  };

  localparam int TX_IDLE [4] = '{0, 75, 0, 36};
  localparam int RX_IDLE [4] = '{0, 0, 75, 36};
  localparam int HIGH_IDS [13] = '{100, 110, 122, 244, 44, 83, 86, 118, 128, 138, 139,
                                    134, 135};

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  in_item_t  in_item = '0;
  logic      push = 1'b0;
  logic      full;
  out_item_t out_item;
  logic      empty;
  logic      pop = 1'b0;

  h264_sps_dimension_parser dut (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .push(push), .full(full),
    .out_item(out_item), .empty(empty), .pop(pop)
  );

  always #4 clk = ~clk;

  out_item_t   dims_expected[$];
  logic [7:0]  bufq[$];
  bit          bitq[$];
  int          tx_idle = 0;
  int          rx_stall = 0;
  int          sent = 0;
  int          quiet = 0;
  bit          failed = 0;
  bit          moved_in;
  bit          moved_out;

  // predictor state
  int unsigned run0, phase, point, zcnt, accum, count, scale_next, profile, cfmt, fl, errc;
  int unsigned mbs [2];
  int unsigned crp [4];

  function automatic int unsigned field_bits(int unsigned p);
    case (p)
      0, 1, 2, 31, 47: return 8;
      5, 8, 9, 10, 15, 21, 24, 25, 26, 27, 29, 30, 33, 34, 35, 37, 39, 41, 44, 45,
      50, 52, 53, 54, 55: return 1;
      32, 42: return 32;
      43: return 33;
      36: return 4;
      38: return 24;
      40: return 10;
      51: return 20;
      default: return 0;
    endcase
  endfunction

  function automatic bit is_high(int unsigned p);
    foreach (HIGH_IDS[i]) if (p == HIGH_IDS[i]) return 1'b1;
    return 1'b0;
  endfunction

  task automatic walk_clear();
    run0 = 0; phase = PH_SEARCH; point = 0; zcnt = 0; accum = 0; count = 0;
    scale_next = 8; profile = 0; cfmt = 1; fl = 0; errc = 0;
    mbs = '{0, 0};
    crp = '{0, 0, 0, 0};
  endtask

  task automatic walk_fail(int unsigned code);
    errc = code;
    phase = PH_DONE;
  endtask

  function automatic int unsigned list_advance();
    mbs[1]++;
    return (mbs[1] < (cfmt == 3 ? 12 : 8)) ? PT_SLFLAG : PT_LOG2FN;
  endfunction

  task automatic walk_take(int unsigned v);
    int unsigned nxt;
    int unsigned d;
    int unsigned s;
    zcnt = 0;
    accum = 0;
    nxt = point + 1;
    case (point)
      PT_PROFILE: profile = v & 255;
      PT_SPSID: nxt = is_high(profile) ? PT_CHROMA : PT_LOG2FN;
      PT_CHROMA: begin
        if (v > 3) begin
          walk_fail(ST_CHROMA);
          return;
        end
        cfmt = v;
        nxt = (v == 3) ? PT_SEPCOL : PT_DEPTHL;
      end
      PT_SMFLAG: begin
        if (v != 0) begin
          mbs[1] = 0;
          nxt = PT_SLFLAG;
        end else nxt = PT_LOG2FN;
      end
      PT_SLFLAG: begin
        if (v != 0) begin
          count = 0;
          scale_next = 8;
          nxt = PT_DELTA;
        end else nxt = list_advance();
      end
      PT_DELTA: begin
        d = (v & 1) ? (v >> 1) + 1 : 0 - (v >> 1);
        s = (scale_next + d) & 255;
        count++;
        if (s == 0 || count >= (mbs[1] < 6 ? 16 : 64)) nxt = list_advance();
        else begin
          scale_next = s;
          nxt = PT_DELTA;
        end
      end
      PT_POCTYPE: nxt = (v == 0) ? PT_POCLSB : ((v == 1) ? PT_DZERO : PT_NUMREF);
      PT_POCLSB: nxt = PT_NUMREF;
      PT_NCYCLE: begin
        mbs[0] = v;
        nxt = (v != 0) ? PT_OFFREF : PT_NUMREF;
      end
      PT_OFFREF: begin
        mbs[0]--;
        nxt = (mbs[0] != 0) ? PT_OFFREF : PT_NUMREF;
      end
      PT_WIDTH: mbs[0] = v;
      PT_HEIGHT: mbs[1] = v;
      PT_FMO: begin
        fl = (fl & 14) | (v & 1);
        nxt = (v != 0) ? PT_D8 : PT_MBAFF;
      end
      PT_CROPF: begin
        fl = (fl & 13) | ((v & 1) << 1);
        if (v != 0) begin
          count = 0;
          nxt = PT_CROP;
        end else nxt = PT_VUIF;
      end
      PT_CROP: begin
        crp[count & 3] = v;
        count++;
        nxt = (count < 4) ? PT_CROP : PT_VUIF;
      end
      PT_VUIF: nxt = (v != 0) ? PT_ARF : PT_DONE;
      PT_ARF: nxt = (v != 0) ? PT_ARIDC : PT_OVF;
      PT_ARIDC: nxt = (v == 255) ? PT_SAR : PT_OVF;
      PT_SAR: nxt = PT_OVF;
      PT_OVF: nxt = (v != 0) ? PT_OVA : PT_VSF;
      PT_VSF: nxt = (v != 0) ? PT_VFMT : PT_CLF;
      PT_CDF: nxt = (v != 0) ? PT_COLOUR : PT_CLF;
      PT_CLF: nxt = (v != 0) ? PT_CLOC : PT_TIF;
      PT_TIF: nxt = (v != 0) ? PT_TICK : PT_NALHRD;
      PT_NALHRD: begin
        if (v != 0) begin
          fl = fl | 12;
          nxt = PT_CPBCNT;
        end else nxt = PT_VCLHRD;
      end
      PT_VCLHRD: begin
        if (v != 0) begin
          fl = (fl | 4) & 7;
          nxt = PT_CPBCNT;
        end else nxt = (fl & 4) ? PT_LOWDELAY : PT_PICSTRUCT;
      end
      PT_CPBCNT: begin
        if (v > 31) begin
          walk_fail(ST_CPB);
          return;
        end
        count = v;
        nxt = PT_SCALES;
      end
      PT_CBR: begin
        if (count == 0) nxt = PT_DELAYS;
        else begin
          count--;
          nxt = PT_BITRATE;
        end
      end
      PT_DELAYS: begin
        if (fl & 8) begin
          fl = fl & 7;
          nxt = PT_VCLHRD;
        end else nxt = PT_LOWDELAY;
      end
      PT_BRF: nxt = (v != 0) ? PT_MVOB : PT_DONE;
      PT_MVOB: begin
        count = 0;
        nxt = PT_RESTR;
      end
      PT_RESTR: begin
        count++;
        nxt = (count < 6) ? PT_RESTR : PT_DONE;
      end
      default: ;
    endcase
    point = nxt;
    if (nxt >= PT_DONE) begin
      point = PT_DONE;
      phase = PH_DONE;
    end
  endtask

  task automatic walk_bit(bit b);
    int unsigned n;
    int unsigned rem;
    if (phase != PH_WALK || point >= PT_DONE) return;
    n = field_bits(point);
    if (n != 0) begin
      accum = (accum << 1) | b;
      zcnt++;
      if (zcnt >= n) walk_take(accum);
    end else if (zcnt & 32) begin
      rem = (zcnt & 31) - 1;
      accum = (accum << 1) | b;
      zcnt = 32 | rem;
      if (rem == 0) walk_take(accum - 1);
    end else if (b) begin
      if (zcnt == 0) walk_take(0);
      else begin
        accum = 1;
        zcnt = zcnt | 32;
      end
    end else if (zcnt >= 31) walk_fail(ST_TRUNC);
    else zcnt++;
  endtask

  function automatic out_item_t size_result();
    out_item_t r;
    longint unsigned w, h, cw, ch, mul, t;
    r = '0;
    w = 0;
    h = 0;
    if (phase < PH_WALK) r.status = ST_NO_SPS;
    else if (errc != 0) r.status = errc[2:0];
    else if (phase == PH_WALK) r.status = ST_TRUNC;
    else begin
      r.status = ST_OK;
      mul = (fl & 1) ? 1 : 2;
      w = mbs[0];
      w = (w + 1) * 16;
      h = mbs[1];
      h = (h + 1) * 16 * mul;
      if (fl & 2) begin
        cw = crp[0];
        t = crp[1];
        cw = (cw + t) * ((cfmt == 1 || cfmt == 2) ? 2 : 1);
        ch = crp[2];
        t = crp[3];
        ch = (ch + t) * ((cfmt == 1) ? 2 : 1) * mul;
        if (cw >= w || ch >= h) r.status = ST_BAD_DIM;
        else begin
          w -= cw;
          h -= ch;
        end
      end
      if (r.status == ST_OK && (w >= 65536 || h >= 65536)) r.status = ST_BAD_DIM;
      if (r.status != ST_OK) begin
        w = 0;
        h = 0;
      end
    end
    r.width = w[15:0];
    r.height = h[15:0];
    return r;
  endfunction

  // advance the predictor by one byte; has_dims tells whether a result is due
  task automatic predict_byte(in_item_t it, output bit has_dims, output out_item_t r);
    int unsigned x;
    x = it.data_byte;
    if (phase == PH_SEARCH) begin
      if (x == 1 && run0 >= 2) begin
        phase = PH_HEADER;
        run0 = 0;
      end else run0 = (x == 0) ? (run0 < 2 ? run0 + 1 : 2) : 0;
    end else if (phase == PH_HEADER) begin
      if ((x & 8'h1F) == 8'h07) begin
        phase = PH_WALK;
        point = PT_PROFILE;
        run0 = 0;
      end else begin
        phase = PH_SEARCH;
        run0 = (x == 0) ? 1 : 0;
      end
    end else if (phase == PH_WALK) begin
      // drop emulation-prevention byte
      if (run0 >= 2 && x == 3) run0 = 0;
      else begin
        for (int i = 7; i >= 0; i--) walk_bit(it.data_byte[i]);
        run0 = (x == 0) ? (run0 < 2 ? run0 + 1 : 2) : 0;
      end
    end
    has_dims = it.last_byte;
    r = '0;
    if (it.last_byte) begin
      r = size_result();
      walk_clear();
    end
  endtask

  task automatic send_byte(in_item_t it, bit typed, out_item_t typed_dims);
    bit has_dims;
    out_item_t r;
    while ($urandom_range(0, 99) < tx_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_byte(it, has_dims, r);
    if (has_dims) dims_expected.push_back(typed ? typed_dims : r);
    sent++;
  endtask

  task automatic put_bits(longint unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) bitq.push_back(v[i]);
  endtask

  task automatic put_ue(longint unsigned v);
    longint unsigned c;
    int n;
    c = v + 1;
    n = 0;
    while ((c >> n) != 0) n++;
    repeat (n - 1) bitq.push_back(1'b0);
    put_bits(c, n);
  endtask

  task automatic put_hrd();
    int cpb;
    cpb = ($urandom_range(0, 19) == 0) ? $urandom_range(32, 40) : $urandom_range(0, 3);
    put_ue(cpb);
    put_bits($urandom, 8);
    if (cpb > 31) return;
    for (int k = 0; k <= cpb; k++) begin
      put_ue($urandom_range(0, 300));
      put_ue($urandom_range(0, 300));
      put_bits($urandom, 1);
    end
    put_bits($urandom, 20);
  endtask

  function automatic longint unsigned pick_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(4090, 4200);
    if (r == 1) return $urandom_range(0, 1 << 20);
    if (r == 2) return 0;
    return $urandom_range(0, 120);
  endfunction

  // well-formed SPS syntax with random content and occasional bad fields
  task automatic gen_sps();
    int unsigned prof, c, v, ns, d, s, pt, n;
    bit f, vui, nal, vcl, crop;
    prof = $urandom_range(0, 1) ? HIGH_IDS[$urandom_range(0, 12)] : $urandom_range(0, 255);
    put_bits(prof, 8);
    put_bits($urandom, 16);
    put_ue($urandom_range(0, 31));
    if (is_high(prof)) begin
      c = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
      put_ue(c);
      if (c == 3) put_bits($urandom, 1);
      put_ue($urandom_range(0, 2));
      put_ue($urandom_range(0, 2));
      put_bits($urandom, 1);
      f = $urandom_range(0, 2) == 0;
      put_bits(f, 1);
      if (f) begin
        for (int i = 0; i < (c == 3 ? 12 : 8); i++) begin
          f = 1'($urandom_range(0, 1));
          put_bits(f, 1);
          if (!f) continue;
          ns = 8;
          for (int j = 0; j < (i < 6 ? 16 : 64); j++) begin
            // sometimes hit a zero next scale to end the list early
            v = ($urandom_range(0, 9) == 0) ? 2 * ns : $urandom_range(0, 6);
            put_ue(v);
            d = (v & 1) ? (v >> 1) + 1 : 0 - (v >> 1);
            s = (ns + d) & 255;
            if (s == 0) break;
            ns = s;
          end
        end
      end
    end
    put_ue($urandom_range(0, 12));
    pt = $urandom_range(0, 3);
    put_ue(pt);
    if (pt == 0) put_ue($urandom_range(0, 12));
    else if (pt == 1) begin
      put_bits($urandom, 1);
      put_ue($urandom_range(0, 50));
      put_ue($urandom_range(0, 50));
      n = $urandom_range(0, 3);
      put_ue(n);
      repeat (n) put_ue($urandom_range(0, 50));
    end
    put_ue($urandom_range(0, 16));
    put_bits($urandom, 1);
    put_ue(pick_dim());
    put_ue(pick_dim());
    f = 1'($urandom_range(0, 1));
    put_bits(f, 1);
    if (!f) put_bits($urandom, 1);
    put_bits($urandom, 1);
    crop = 1'($urandom_range(0, 1));
    put_bits(crop, 1);
    if (crop) repeat (4) put_ue($urandom_range(0, 7) == 0 ? $urandom_range(0, 3000)
                                                          : $urandom_range(0, 8));
    vui = 1'($urandom_range(0, 1));
    put_bits(vui, 1);
    if (vui) begin
      f = 1'($urandom_range(0, 1));
      put_bits(f, 1);
      if (f) begin
        v = $urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 255);
        put_bits(v, 8);
        if (v == 255) put_bits($urandom, 32);
      end
      f = 1'($urandom_range(0, 1));
      put_bits(f, 1);
      if (f) put_bits($urandom, 1);
      f = 1'($urandom_range(0, 1));
      put_bits(f, 1);
      if (f) begin
        put_bits($urandom, 4);
        f = 1'($urandom_range(0, 1));
        put_bits(f, 1);
        if (f) put_bits($urandom, 24);
      end
      f = 1'($urandom_range(0, 1));
      put_bits(f, 1);
      if (f) put_bits($urandom, 10);
      f = 1'($urandom_range(0, 1));
      put_bits(f, 1);
      if (f) begin
        put_bits($urandom, 32);
        put_bits($urandom, 32);
        put_bits($urandom, 1);
      end
      nal = 1'($urandom_range(0, 1));
      put_bits(nal, 1);
      if (nal) put_hrd();
      vcl = 1'($urandom_range(0, 1));
      put_bits(vcl, 1);
      if (vcl) put_hrd();
      if (nal || vcl) put_bits($urandom, 1);
      put_bits($urandom, 1);
      f = 1'($urandom_range(0, 1));
      put_bits(f, 1);
      if (f) begin
        put_bits($urandom, 1);
        repeat (6) put_ue($urandom_range(0, 16));
      end
    end
  endtask

  // pack bits into payload bytes with emulation prevention
  task automatic pack_payload();
    logic [7:0] b;
    int zeros;
    bitq.push_back(1'b1);
    while (bitq.size() % 8 != 0) bitq.push_back(1'b0);
    zeros = 0;
    while (bitq.size() != 0) begin
      for (int i = 7; i >= 0; i--) b[i] = bitq.pop_front();
      if (zeros >= 2 && b <= 3) begin
        bufq.push_back(8'h03);
        zeros = 0;
      end
      bufq.push_back(b);
      zeros = (b == 0) ? zeros + 1 : 0;
    end
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0, 1: return 8'h00;
      2: return 8'h01;
      3: return 8'h03;
      4: return {3'($urandom_range(0, 7)), 5'h07};
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_buffer();
    int r, n;
    in_item_t it;
    bufq.delete();
    bitq.delete();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      n = $urandom_range(1, 20);
      repeat (n) bufq.push_back(noise_byte());
    end else begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) bufq.push_back(noise_byte());
      if ($urandom_range(0, 4) == 0) begin
        // another NAL unit ahead of the SPS
        bufq.push_back(8'h00);
        bufq.push_back(8'h00);
        bufq.push_back(8'h01);
        bufq.push_back({3'($urandom_range(0, 7)), 5'd1 + 5'($urandom_range(0, 4))});
        repeat ($urandom_range(0, 5)) bufq.push_back(8'($urandom_range(4, 255)));
      end
      if ($urandom_range(0, 1)) bufq.push_back(8'h00);
      bufq.push_back(8'h00);
      bufq.push_back(8'h00);
      bufq.push_back(8'h01);
      bufq.push_back({3'($urandom_range(0, 7)), 5'h07});
      if (r < 16) repeat ($urandom_range(0, 12)) bufq.push_back(noise_byte());
      else begin
        if (r < 21) begin
          // Exp-Golomb prefix around the longest legal length
          put_bits(66, 8);
          put_bits($urandom, 16);
          repeat ($urandom_range(30, 33)) bitq.push_back(1'b0);
          bitq.push_back(1'b1);
          put_bits($urandom, 32);
        end else gen_sps();
        pack_payload();
        if ($urandom_range(0, 6) == 0) begin
          n = $urandom_range(1, bufq.size());
          while (bufq.size() > n) void'(bufq.pop_back());
        end
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) bufq.push_back(noise_byte());
      end
    end
    foreach (bufq[i]) begin
      it.data_byte = bufq[i];
      it.last_byte = (i == bufq.size() - 1);
      send_byte(it, 1'b0, '0);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (dims_expected.size() != 0) @(posedge clk);
  endtask

  // result side: random stall, compare each transfer with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    moved_out = rst_n && pop && !empty;
    if (moved_out) begin
      if (dims_expected.size() == 0) begin
        $display("%0t: unexpected result status=%0d width=%0d height=%0d", $time,
                 out_item.status, out_item.width, out_item.height);
        failed = 1;
      end else begin
        want = dims_expected.pop_front();
        if (out_item.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_item.status);
          failed = 1;
        end
        if (out_item.width !== want.width) begin
          $display("%0t: width expected %0d actual %0d", $time, want.width, out_item.width);
          failed = 1;
        end
        if (out_item.height !== want.height) begin
          $display("%0t: height expected %0d actual %0d", $time, want.height, out_item.height);
          failed = 1;
        end
      end
    end
    pop <= ($urandom_range(0, 99) >= rx_stall);
  end

  always @(posedge clk) begin
    moved_in = rst_n && push && !full;
    if (!rst_n || moved_in || (pop && !empty)) quiet <= 0;
    else if (quiet >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else quiet <= quiet + 1;
  end

  initial begin
    in_item_t it;
    out_item_t typed_dims;
    walk_clear();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < DIR_ROWS; i++) begin
      it.data_byte = DIR_TAB[i].data;
      it.last_byte = DIR_TAB[i].last;
      typed_dims.status = DIR_TAB[i].status;
      typed_dims.width = DIR_TAB[i].width;
      typed_dims.height = DIR_TAB[i].height;
      send_byte(it, DIR_TAB[i].typed, typed_dims);
    end
    for (int ph = 0; ph < 4; ph++) begin
      // hold off until the block has handed over every result
      wait_drained();
      tx_idle = TX_IDLE[ph];
      rx_stall = RX_IDLE[ph];
      n_target: begin
        int goal;
        goal = sent + PHASE_ITEMS;
        while (sent < goal) send_random_buffer();
      end
    end
    wait_drained();
    repeat (40) @(posedge clk);
    if (!failed) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
